// ===== src/mfrm_pkg.sv =====
`default_nettype none

package mfrm_pkg;

    // table geometry
    localparam int MAX_RULES   = 64;
    localparam int NUM_DIMS    = 6;
    localparam int VALUE_WIDTH = 32;

    localparam int RULE_W  = $clog2(MAX_RULES);
    localparam int DIM_W   = 3;
    localparam int COUNT_W = $clog2(MAX_RULES + 1);
    localparam int CFG_W   = 7;

    // one lane holds {high, low} of one dimension for every rule
    localparam int LANE_W = 2 * VALUE_WIDTH;

    // request kinds carried on s_tuser
    localparam logic REQ_LOAD     = 1'b0;
    localparam logic REQ_CLASSIFY = 1'b1;

    // s_tdata layout
    localparam int RULE_LSB     = 0;
    localparam int DIM_LSB      = RULE_LSB + RULE_W;
    localparam int LOW_LSB      = DIM_LSB + DIM_W;
    localparam int HIGH_LSB     = LOW_LSB + VALUE_WIDTH;
    localparam int KEY_LSB      = HIGH_LSB + VALUE_WIDTH;
    localparam int S_TDATA_BITS = KEY_LSB + NUM_DIMS * VALUE_WIDTH;
    localparam int S_TDATA_W    = ((S_TDATA_BITS + 7) / 8) * 8;

    // m_tdata layout
    localparam int M_TDATA_BITS = 1 + RULE_W;
    localparam int M_TDATA_W    = ((M_TDATA_BITS + 7) / 8) * 8;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_RULE_COUNT = '0;

    typedef struct packed {
        logic write_rule;
        logic start;
        logic scan;
        logic capture;
        logic load_out;
    } mfrm_cmd_t;

    typedef struct packed {
        logic hit;
        logic exhausted;
        logic out_free;
    } mfrm_status_t;

endpackage

`default_nettype wire

// ===== src/mfrm_ram.sv =====
`default_nettype none

module mfrm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/mfrm_ctrl.sv =====
`default_nettype none

module mfrm_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tuser,
    output logic                       s_tready,
    input  wire mfrm_pkg::mfrm_status_t status,
    output mfrm_pkg::mfrm_cmd_t        cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_POST = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == mfrm_pkg::REQ_LOAD) begin
                        cmd.write_rule = 1'b1;
                    end else begin
                        cmd.start  = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.hit || status.exhausted) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_POST;
                end
            end
            ST_POST: begin
                // wait for the output register to free up
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/mfrm_datapath.sv =====
`default_nettype none

module mfrm_datapath (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic [mfrm_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [mfrm_pkg::CFG_W-1:0]       rule_count,
    input  wire mfrm_pkg::mfrm_cmd_t              cmd,
    output mfrm_pkg::mfrm_status_t                status,
    input  wire logic                             m_tready,
    output logic                                  m_tvalid,
    output logic      [mfrm_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int RW = mfrm_pkg::RULE_W;
    localparam int CW = mfrm_pkg::COUNT_W;
    localparam int VW = mfrm_pkg::VALUE_WIDTH;
    localparam int PAD_W = mfrm_pkg::M_TDATA_W - mfrm_pkg::M_TDATA_BITS;

    logic [VW-1:0] key_reg [mfrm_pkg::NUM_DIMS];

    logic [CW-1:0] limit_reg, limit_next;
    logic [CW-1:0] issue_ptr_reg;
    logic          cmp_valid_reg;
    logic [RW-1:0] cmp_idx_reg;
    logic          res_found_reg;
    logic [RW-1:0] res_idx_reg;
    logic          out_valid_reg;
    logic          out_found_reg;
    logic [RW-1:0] out_idx_reg;

    logic [mfrm_pkg::NUM_DIMS-1:0] lane_hit;
    logic                          all_hit;
    logic                          can_issue;

    logic [RW-1:0]                   wr_rule;
    logic [mfrm_pkg::DIM_W-1:0]      wr_dim;
    logic [mfrm_pkg::LANE_W-1:0]     wr_data;

    assign wr_rule = s_tdata[mfrm_pkg::RULE_LSB +: RW];
    assign wr_dim  = s_tdata[mfrm_pkg::DIM_LSB +: mfrm_pkg::DIM_W];
    assign wr_data = {s_tdata[mfrm_pkg::HIGH_LSB +: VW], s_tdata[mfrm_pkg::LOW_LSB +: VW]};

    assign limit_next = (rule_count > mfrm_pkg::CFG_W'(mfrm_pkg::MAX_RULES))
                        ? CW'(mfrm_pkg::MAX_RULES) : CW'(rule_count);
    assign can_issue  = (issue_ptr_reg < limit_reg);

    // one lane per dimension, read together at one rule per cycle
    for (genvar d = 0; d < mfrm_pkg::NUM_DIMS; d++) begin : g_lane
        logic [mfrm_pkg::LANE_W-1:0] lane_rdata;
        logic [VW-1:0]               lo;
        logic [VW-1:0]               hi;

        mfrm_ram #(
            .WIDTH (mfrm_pkg::LANE_W),
            .DEPTH (mfrm_pkg::MAX_RULES)
        ) u_ram (
            .aclk  (aclk),
            .we    (cmd.write_rule && (wr_dim == mfrm_pkg::DIM_W'(d))),
            .waddr (wr_rule),
            .wdata (wr_data),
            .raddr (issue_ptr_reg[RW-1:0]),
            .rdata (lane_rdata)
        );

        assign lo = lane_rdata[VW-1:0];
        assign hi = lane_rdata[2*VW-1:VW];
        assign lane_hit[d] = (key_reg[d] >= lo) && (key_reg[d] <= hi);

        always_ff @(posedge aclk) begin
            if (cmd.start) begin
                key_reg[d] <= s_tdata[mfrm_pkg::KEY_LSB + d*VW +: VW];
            end
        end
    end

    assign all_hit = &lane_hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_valid_reg <= 1'b0;
            issue_ptr_reg <= '0;
            limit_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.start) begin
                cmp_valid_reg <= 1'b0;
                issue_ptr_reg <= '0;
                limit_reg     <= limit_next;
            end else if (cmd.scan) begin
                if (can_issue) begin
                    cmp_valid_reg <= 1'b1;
                    issue_ptr_reg <= issue_ptr_reg + CW'(1);
                end else begin
                    cmp_valid_reg <= 1'b0;
                end
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan && can_issue) begin
            cmp_idx_reg <= issue_ptr_reg[RW-1:0];
        end
        if (cmd.capture) begin
            res_found_reg <= status.hit;
            res_idx_reg   <= status.hit ? cmp_idx_reg : '0;
        end
        if (cmd.load_out) begin
            out_found_reg <= res_found_reg;
            out_idx_reg   <= res_idx_reg;
        end
    end

    assign status.hit       = cmp_valid_reg && all_hit;
    assign status.exhausted = !cmp_valid_reg && !can_issue;
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_idx_reg, out_found_reg};

endmodule

`default_nettype wire

// ===== src/multi_field_range_rule_match_core.sv =====
// load: a load request is written at its accepting edge and gives no result
// classify: m_tvalid rises once the scan stops at the first matching rule r, or on a miss
//   after n = min(rule_count, 64) rules scanned, with no rule read when n is zero
// requests: after a classify none is taken until its result enters the output register,
//   which waits while the previous result is held; one load request per cycle while idle
// reset: aresetn synchronous active low, clears control state, rule_count and m_tvalid only
`default_nettype none

module multi_field_range_rule_match_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    // request channel
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // rule_index[5:0], dim_index[8:6], range_low[40:9], range_high[72:41],
    // key_0[104:73], key_1[136:105], key_2[168:137], key_3[200:169],
    // key_4[232:201], key_5[264:233], zero pad
    input  wire logic [mfrm_pkg::S_TDATA_W-1:0]    s_tdata,
    // req_type[0]: 0 load rule range, 1 classify packet
    input  wire logic                              s_tuser,

    // result channel
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // match_found[0], match_index[6:1], zero pad
    output logic      [mfrm_pkg::M_TDATA_W-1:0]    m_tdata,

    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mfrm_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [mfrm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [mfrm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);

    // register index from the word address, byte offset dropped
    logic [mfrm_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           cfg_write;
    logic [mfrm_pkg::CFG_W-1:0]     rule_count_reg;

    mfrm_pkg::mfrm_cmd_t    cmd;
    mfrm_pkg::mfrm_status_t status;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[mfrm_pkg::APB_ADDR_W-1:2];
    // access phase of a write
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rule_count_reg <= '0;
        end else if (cfg_write && (reg_idx == mfrm_pkg::REG_RULE_COUNT)) begin
            rule_count_reg <= pwdata[mfrm_pkg::CFG_W-1:0];
        end
    end

    // reads of unknown registers return zero
    always_comb begin
        prdata = '0;
        if (reg_idx == mfrm_pkg::REG_RULE_COUNT) begin
            prdata = {{(mfrm_pkg::APB_DATA_W - mfrm_pkg::CFG_W){1'b0}}, rule_count_reg};
        end
    end

    // sequencer: idle, rule scan, hand-off to the output register
    mfrm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // rule lanes, comparators, scan pointer and output register
    mfrm_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tdata    (s_tdata),
        .rule_count (rule_count_reg),
        .cmd        (cmd),
        .status     (status),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

// ===== src/mfrm_checker.sv =====
`default_nettype none

module mfrm_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           s_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [mfrm_pkg::M_TDATA_W-1:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a classify blocks further requests while the scan runs
    a_classify_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == mfrm_pkg::REQ_CLASSIFY) |=> !s_tready)
        else $error("request taken during scan");

    // a load request never stalls the channel
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == mfrm_pkg::REQ_LOAD) |=> s_tready)
        else $error("load request stalled channel");

    // no match reports index zero
    a_miss_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> (m_tdata[mfrm_pkg::RULE_W:1] == '0))
        else $error("nonzero index on miss");

endmodule

bind multi_field_range_rule_match_core mfrm_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== bench/tb_multi_field_range_rule_match_core.sv =====
module tb_multi_field_range_rule_match_core;
    import mfrm_pkg::*;

    // cycles to let pass once the last result is in: a full scan plus pipeline slack
    localparam int SCAN_SETTLE = MAX_RULES + 8;
    // byte addresses on the configuration port
    localparam logic [APB_ADDR_W-1:0] RULE_COUNT_ADDR = {REG_RULE_COUNT, 2'b00};
    // register index 1 does not exist, writes there must leave rule_count alone
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = 3'd4;
    // receiver hold-off that backs the block up into its request channel
    localparam int LONG_HOLD = 400;
    localparam int HOLD_AFTER_RESULTS = 40;

    // one key per dimension, dimension 0 in the low word
    typedef logic [NUM_DIMS-1:0][VALUE_WIDTH-1:0] key_set_t;

    typedef struct packed {
        logic              found;
        logic [RULE_W-1:0] index;
    } match_result_t;

    // shadow of the rule table and rule_count, predicts one match result per classify
    class classifier_model;
        logic [VALUE_WIDTH-1:0] lo_tab [MAX_RULES*NUM_DIMS];
        logic [VALUE_WIDTH-1:0] hi_tab [MAX_RULES*NUM_DIMS];
        bit                     loaded [MAX_RULES][NUM_DIMS];
        logic [CFG_W-1:0]       rule_count;
        match_result_t          pending_matches [$];
        int                     errors;

        function new();
            foreach (lo_tab[i]) begin
                lo_tab[i] = '0;
                hi_tab[i] = '0;
            end
            foreach (loaded[r, d]) loaded[r][d] = 1'b0;
            rule_count = '0;
            errors = 0;
        endfunction

        function void write_register(int idx, logic [APB_DATA_W-1:0] value);
            if (idx == int'(REG_RULE_COUNT)) rule_count = value[CFG_W-1:0];
        endfunction

        function bit rule_hits(int r, key_set_t keys);
            for (int d = 0; d < NUM_DIMS; d++) begin
                if (keys[d] < lo_tab[r*NUM_DIMS+d] || keys[d] > hi_tab[r*NUM_DIMS+d])
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        // note one accepted request: a load updates the table, a classify queues its answer
        function void accept_request(logic kind, logic [S_TDATA_W-1:0] data);
            int            rule;
            int            dim;
            int            limit;
            key_set_t      keys;
            match_result_t res;
            if (kind == REQ_LOAD) begin
                rule = int'(data[RULE_LSB +: RULE_W]);
                dim  = int'(data[DIM_LSB +: DIM_W]);
                // dimensions beyond the last are dropped by the block
                if (dim < NUM_DIMS) begin
                    lo_tab[rule*NUM_DIMS+dim] = data[LOW_LSB +: VALUE_WIDTH];
                    hi_tab[rule*NUM_DIMS+dim] = data[HIGH_LSB +: VALUE_WIDTH];
                    loaded[rule][dim] = 1'b1;
                end
            end else begin
                keys  = data[KEY_LSB +: NUM_DIMS*VALUE_WIDTH];
                limit = (int'(rule_count) > MAX_RULES) ? MAX_RULES : int'(rule_count);
                res   = '0;
                for (int r = 0; r < limit; r++) begin
                    if (rule_hits(r, keys)) begin
                        res.found = 1'b1;
                        res.index = r[RULE_W-1:0];
                        break;
                    end
                end
                pending_matches.push_back(res);
            end
        endfunction

        function void compare_match(logic [M_TDATA_W-1:0] data);
            match_result_t     want;
            logic              found;
            logic [RULE_W-1:0] index;
            found = data[0];
            index = data[1 +: RULE_W];
            if (pending_matches.size() == 0) begin
                errors++;
                $display("%0t: result with no classify outstanding: found=%0b index=%0d",
                         $time, found, index);
                return;
            end
            want = pending_matches.pop_front();
            if (found !== want.found) begin
                errors++;
                $display("%0t: match_found expected %0b actual %0b",
                         $time, want.found, found);
            end
            if (index !== want.index) begin
                errors++;
                $display("%0t: match_index expected %0d actual %0d",
                         $time, want.index, index);
            end
        endfunction

        function int outstanding();
            return pending_matches.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    classifier_model model_h = new();
    // no idling on either side once set
    bit quiet_tail = 1'b0;

    multi_field_range_rule_match_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock, period 10
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // request word layout follows the package field offsets, pad bits stay zero
    function automatic logic [S_TDATA_W-1:0] pack_request(
        logic [RULE_W-1:0] rule, logic [DIM_W-1:0] dim,
        logic [VALUE_WIDTH-1:0] lo, logic [VALUE_WIDTH-1:0] hi, key_set_t keys);
        logic [S_TDATA_W-1:0] data;
        data = '0;
        data[RULE_LSB +: RULE_W] = rule;
        data[DIM_LSB +: DIM_W] = dim;
        data[LOW_LSB +: VALUE_WIDTH] = lo;
        data[HIGH_LSB +: VALUE_WIDTH] = hi;
        data[KEY_LSB +: NUM_DIMS*VALUE_WIDTH] = keys;
        return data;
    endfunction

    function automatic key_set_t random_keys();
        key_set_t keys;
        for (int d = 0; d < NUM_DIMS; d++) keys[d] = $urandom;
        return keys;
    endfunction

    function automatic key_set_t uniform_keys(logic [VALUE_WIDTH-1:0] v);
        key_set_t keys;
        for (int d = 0; d < NUM_DIMS; d++) keys[d] = v;
        return keys;
    endfunction

    // returns {high, low}, a mix of full, point, empty, narrow and edge-anchored ranges
    function automatic logic [2*VALUE_WIDTH-1:0] random_range();
        logic [VALUE_WIDTH-1:0] a;
        logic [VALUE_WIDTH-1:0] b;
        logic [VALUE_WIDTH-1:0] t;
        a = $urandom;
        b = $urandom;
        case ($urandom_range(0, 7))
            0: begin
                a = '0;
                b = '1;
            end
            1: b = a;
            // empty: low above high
            2: if (a < b) begin
                t = a;
                a = b;
                b = t;
            end
            3: begin
                b = a + ($urandom & 32'h0000_0fff);
                if (b < a) b = '1;
            end
            4: begin
                a = '0;
            end
            5: begin
                b = '1;
            end
            default: if (a > b) begin
                t = a;
                a = b;
                b = t;
            end
        endcase
        return {b, a};
    endfunction

    // keys aimed at one rule so that matches are common, with some dimensions knocked out
    function automatic key_set_t pick_keys(int limit);
        key_set_t               keys;
        int                     target;
        int                     slot;
        logic [VALUE_WIDTH-1:0] lo;
        logic [VALUE_WIDTH-1:0] hi;
        logic [63:0]            span;
        logic [63:0]            offset;
        keys = random_keys();
        if ($urandom_range(0, 6) == 0) return keys;
        target = $urandom_range(0, (limit > 0) ? limit - 1 : MAX_RULES - 1);
        for (int d = 0; d < NUM_DIMS; d++) begin
            slot = target * NUM_DIMS + d;
            lo = model_h.lo_tab[slot];
            hi = model_h.hi_tab[slot];
            if (lo <= hi && $urandom_range(0, 11) != 0) begin
                span = {32'h0, hi} - {32'h0, lo} + 64'd1;
                case ($urandom_range(0, 3))
                    0: keys[d] = lo;
                    1: keys[d] = hi;
                    default: begin
                        offset = {$urandom, $urandom} % span;
                        keys[d] = lo + offset[VALUE_WIDTH-1:0];
                    end
                endcase
            end
        end
        return keys;
    endfunction

    // offer one request and hold it until accepted; valid stays up unless a gap follows
    task automatic send_request(input logic kind, input logic [S_TDATA_W-1:0] data);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        model_h.accept_request(kind, data);
        // random sender gap
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    task automatic send_load(input logic [RULE_W-1:0] rule, input logic [DIM_W-1:0] dim,
                             input logic [VALUE_WIDTH-1:0] lo,
                             input logic [VALUE_WIDTH-1:0] hi);
        // keys are unused by a load, fill them with noise
        send_request(REQ_LOAD, pack_request(rule, dim, lo, hi, random_keys()));
    endtask

    task automatic load_random_range(input int rule, input int dim);
        logic [2*VALUE_WIDTH-1:0] rng;
        rng = random_range();
        send_load(rule[RULE_W-1:0], dim[DIM_W-1:0], rng[VALUE_WIDTH-1:0],
                  rng[2*VALUE_WIDTH-1:VALUE_WIDTH]);
    endtask

    task automatic send_classify(input key_set_t keys);
        // load fields are unused by a classify, fill them with noise
        send_request(REQ_CLASSIFY, pack_request(RULE_W'($urandom), DIM_W'($urandom),
                                                $urandom, $urandom, keys));
    endtask

    // stop offering, wait for every outstanding result, then let the block settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (model_h.outstanding() != 0) @(posedge aclk);
        repeat (SCAN_SETTLE) @(posedge aclk);
    endtask

    // setup cycle then access cycle, register takes the write on the access edge
    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        model_h.write_register(int'(addr[APB_ADDR_W-1:2]), data);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // read rule_count back and compare with the shadow copy
    task automatic read_rule_count();
        logic [APB_DATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= RULE_COUNT_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        got = prdata;
        if (got[CFG_W-1:0] !== model_h.rule_count) begin
            model_h.errors++;
            $display("%0t: rule_count readback expected %0d actual %0d",
                     $time, model_h.rule_count, got[CFG_W-1:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // reprogram rule_count while the block is idle, upper data bits carry noise
    task automatic set_rule_count(input int count, input bit touch_spare);
        logic [APB_DATA_W-1:0] word;
        word = $urandom;
        word[CFG_W-1:0] = count[CFG_W-1:0];
        drain_results();
        apb_write(RULE_COUNT_ADDR, word);
        read_rule_count();
        if (touch_spare) begin
            apb_write(SPARE_ADDR, $urandom);
            read_rule_count();
        end
    endtask

    // one setting of rule_count followed by a random mix of loads and classifies
    task automatic run_phase(input int count, input int n_items);
        int limit;
        set_rule_count(count, 1'($urandom_range(0, 1)));
        limit = (count > MAX_RULES) ? MAX_RULES : count;
        // every rule in the scan must be loaded in all dimensions before a classify
        for (int r = 0; r < limit; r++) begin
            for (int d = 0; d < NUM_DIMS; d++) begin
                if (!model_h.loaded[r][d]) load_random_range(r, d);
            end
        end
        for (int i = 0; i < n_items; i++) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3: begin
                    load_random_range($urandom_range(0, MAX_RULES - 1),
                                      $urandom_range(0, NUM_DIMS - 1));
                end
                // load to a dimension that does not exist
                4: begin
                    load_random_range($urandom_range(0, MAX_RULES - 1),
                                      $urandom_range(NUM_DIMS, 7));
                end
                default: begin
                    send_classify(pick_keys(limit));
                end
            endcase
        end
    endtask

    // result side: checks each accepted result, random back-pressure, one long hold
    initial begin : result_sink
        int results_seen;
        int stall_left;
        int hold_left;
        bit held;
        results_seen = 0;
        stall_left   = 0;
        hold_left    = 0;
        held         = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                model_h.compare_match(m_tdata);
                results_seen++;
            end
            if (hold_left > 0) begin
                // long hold, the block fills up and stalls its request channel
                hold_left--;
                m_tready <= 1'b0;
            end else if (!held && results_seen == HOLD_AFTER_RESULTS) begin
                held = 1'b1;
                hold_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                // short random stall burst
                stall_left = $urandom_range(1, 7) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // request side: reset, directed requests, random phases, final verdict
    initial begin : request_source
        key_set_t keys;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= REQ_LOAD;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // rule_count is zero out of reset, nothing can match and no entry is read
        send_classify(uniform_keys('0));
        send_classify(uniform_keys('1));

        // rule 0: [0x10, 0x20] except an empty range in dimension 2
        // rule 1: full span except dimension 0 pinned at the top value
        for (int d = 0; d < NUM_DIMS; d++) begin
            if (d == 2) send_load(RULE_W'(0), DIM_W'(d), 32'h5, 32'h4);
            else send_load(RULE_W'(0), DIM_W'(d), 32'h10, 32'h20);
            send_load(RULE_W'(1), DIM_W'(d), (d == 0) ? 32'hffff_ffff : 32'h0, 32'hffff_ffff);
        end
        // top rule and top dimension
        send_load(RULE_W'(MAX_RULES - 1), DIM_W'(NUM_DIMS - 1), 32'h0, 32'hffff_ffff);

        set_rule_count(2, 1'b1);

        // rule 0 blocked by its empty range, rule 1 misses on dimension 0
        send_classify(uniform_keys(32'h10));
        // only rule 1 matches
        keys = uniform_keys('0);
        keys[0] = 32'hffff_ffff;
        send_classify(keys);
        // loads to dimensions 6 and 7 are dropped, rule 1 dimension 0 must survive
        send_load(RULE_W'(0), DIM_W'(6), 32'h0, 32'h0);
        send_load(RULE_W'(1), DIM_W'(7), 32'h0, 32'h0);
        keys = uniform_keys(32'h18);
        keys[0] = 32'hffff_ffff;
        send_classify(keys);
        // open up rule 0, both bounds inclusive
        send_load(RULE_W'(0), DIM_W'(2), 32'h10, 32'h20);
        send_classify(uniform_keys(32'h10));
        send_classify(uniform_keys(32'h20));
        send_classify(uniform_keys(32'h21));
        send_classify(uniform_keys('1));

        // random phases through small, zero, full and oversized counts
        run_phase(5, 20);
        run_phase(1, 15);
        run_phase(MAX_RULES, 25);
        run_phase(127, 20);
        run_phase(0, 10);
        run_phase(37, 20);
        run_phase(100, 20);
        run_phase(2, 15);
        run_phase(MAX_RULES, 25);
        // last stretch without idling on either side
        quiet_tail = 1'b1;
        run_phase(MAX_RULES, 30);

        drain_results();
        if (model_h.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // hard stop far beyond the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("%0t: timeout, results still outstanding: %0d", $time,
                 model_h.outstanding());
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== multi_field_range_rule_match_core.f =====
src/mfrm_pkg.sv
src/mfrm_ram.sv
src/mfrm_ctrl.sv
src/mfrm_datapath.sv
src/multi_field_range_rule_match_core.sv
src/mfrm_checker.sv
bench/tb_multi_field_range_rule_match_core.sv
